>>> hdl/crc32a_pkg.sv
// Shared types and constants for the CRC-32 accumulator.
// No dependencies; every other file refers to this package by scoped names.
package crc32a_pkg;

  localparam int unsigned CRC_W       = 32;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_BYTES_D = 8;

  localparam logic [CRC_W-1:0] POLY_IEEE       = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] POLY_CASTAGNOLI = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] OUT_XOR         = 32'hFFFF_FFFF;

  // item mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ABSORB = 1'b1;

  // poly_select codes
  localparam logic POLY_SEL_IEEE = 1'b0;
  localparam logic POLY_SEL_CAST = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // per-cycle controls from the sequencer state decode
  typedef struct packed {
    logic in_ready;
    logic do_byte;
    logic do_out;
  } seq_ctrl_t;

endpackage

>>> hdl/crc32a_if.sv
// Valid/ready channel interfaces for item and result transfers.
// Depends on crc32a_pkg for field widths.
interface crc32a_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [crc32a_pkg::VALUE_W-1:0]     value;
  logic [crc32a_pkg::COUNT_W-1:0]     byte_count;

  modport source (output valid, mode, value, byte_count, input ready);
  modport sink   (input valid, mode, value, byte_count, output ready);
endinterface

interface crc32a_out_if;
  logic                               valid;
  logic                               ready;
  logic [crc32a_pkg::CRC_W-1:0]       crc_out;

  modport source (output valid, crc_out, input ready);
  modport sink   (input valid, crc_out, output ready);
endinterface

>>> hdl/crc32a_byte_unit.sv
// Shared one-byte reflected CRC update: XOR byte into low bits, then eight shifts.
// Depends on crc32a_pkg.
module crc32a_byte_unit (
  input  logic [crc32a_pkg::CRC_W-1:0]  crc_in,
  input  logic [crc32a_pkg::BYTE_W-1:0] data_in,
  input  logic [crc32a_pkg::CRC_W-1:0]  poly,
  output logic [crc32a_pkg::CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [crc32a_pkg::CRC_W-1:0] c;
    c = crc_in ^ {{(crc32a_pkg::CRC_W-crc32a_pkg::BYTE_W){1'b0}}, data_in};
    for (int b = 0; b < crc32a_pkg::BYTE_W; b++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

>>> hdl/crc32a_seq.sv
// Item sequencer: holds the CRC register, feeds one byte per cycle to the
// shared update unit and registers the result. Depends on crc32a_pkg, crc32a_if.
module crc32a_seq #(
  parameter int unsigned MAX_BYTES = crc32a_pkg::MAX_BYTES_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  crc32a_in_if.sink                     in_chan,
  crc32a_out_if.source                  out_chan,
  output logic [crc32a_pkg::CRC_W-1:0]  unit_crc,
  output logic [crc32a_pkg::BYTE_W-1:0] unit_data,
  input  logic [crc32a_pkg::CRC_W-1:0]  unit_result
);

  localparam logic [crc32a_pkg::COUNT_W-1:0] MAX_CNT = crc32a_pkg::COUNT_W'(MAX_BYTES);

  crc32a_pkg::seq_state_t state_r, state_nxt;
  crc32a_pkg::seq_ctrl_t  ctrl;

  logic [crc32a_pkg::CRC_W-1:0]   crc_r, crc_nxt;
  logic [crc32a_pkg::VALUE_W-1:0] data_r, data_nxt;
  logic [crc32a_pkg::COUNT_W-1:0] remain_r, remain_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [crc32a_pkg::CRC_W-1:0]   out_crc_r, out_crc_nxt;
  logic                           out_free;
  logic                           in_xfer;
  logic [crc32a_pkg::COUNT_W-1:0] cnt_sat;

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_xfer  = in_chan.valid && ctrl.in_ready;
  assign cnt_sat  = (in_chan.byte_count > MAX_CNT) ? MAX_CNT : in_chan.byte_count;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crc32a_pkg::ST_IDLE: if (in_chan.valid) state_nxt = crc32a_pkg::ST_RUN;
      crc32a_pkg::ST_RUN:  if (remain_r == '0 && out_free) state_nxt = crc32a_pkg::ST_IDLE;
      default:             state_nxt = crc32a_pkg::ST_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    ctrl = '0;
    case (state_r)
      crc32a_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      crc32a_pkg::ST_RUN: begin
        ctrl.do_byte = (remain_r != '0);
        ctrl.do_out  = (remain_r == '0) && out_free;
      end
      default: ctrl = '0;
    endcase
  end

  assign unit_crc  = crc_r;
  assign unit_data = data_r[crc32a_pkg::BYTE_W-1:0];

  // datapath
  always_comb begin
    crc_nxt       = crc_r;
    data_nxt      = data_r;
    remain_nxt    = remain_r;
    out_crc_nxt   = out_crc_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (in_xfer) begin
      data_nxt = in_chan.value;
      if (in_chan.mode == crc32a_pkg::MODE_LOAD) begin
        crc_nxt    = in_chan.value[crc32a_pkg::CRC_W-1:0];
        remain_nxt = '0;
      end else begin
        remain_nxt = cnt_sat;
      end
    end
    if (ctrl.do_byte) begin
      crc_nxt    = unit_result;
      data_nxt   = data_r >> crc32a_pkg::BYTE_W;
      remain_nxt = remain_r - 1'b1;
    end
    if (ctrl.do_out) begin
      out_crc_nxt   = crc_r ^ crc32a_pkg::OUT_XOR;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crc32a_pkg::ST_IDLE;
      crc_r       <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    out_crc_r <= out_crc_nxt;
  end

  assign in_chan.ready    = ctrl.in_ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.crc_out = out_crc_r;

endmodule

>>> hdl/crc32_accumulator_core.sv
// A load sets the CRC register and returns a result with no byte steps; an absorb of N
// bytes (N saturated to MAX_BYTES) runs one byte per cycle through the shared byte
// update unit. A new item is taken only after the previous result has been registered.
// Reset (rst_n low, synchronous): CRC register cleared, IEEE polynomial selected,
// no result pending.
module crc32_accumulator_core #(
  parameter int unsigned MAX_BYTES = crc32a_pkg::MAX_BYTES_D
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  crc32a_in_if.sink      in_chan,
  crc32a_out_if.source   out_chan
);

  logic                          poly_sel_r;
  logic [crc32a_pkg::CRC_W-1:0]  poly;
  logic [crc32a_pkg::CRC_W-1:0]  unit_crc;
  logic [crc32a_pkg::BYTE_W-1:0] unit_data;
  logic [crc32a_pkg::CRC_W-1:0]  unit_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_sel_r <= crc32a_pkg::POLY_SEL_IEEE;
    end else if (cfg_we) begin
      poly_sel_r <= cfg_wdata;
    end
  end

  assign poly = (poly_sel_r == crc32a_pkg::POLY_SEL_CAST) ? crc32a_pkg::POLY_CASTAGNOLI
                                                          : crc32a_pkg::POLY_IEEE;

  crc32a_byte_unit u_unit (
    .crc_in  (unit_crc),
    .data_in (unit_data),
    .poly    (poly),
    .crc_out (unit_result)
  );

  crc32a_seq #(
    .MAX_BYTES (MAX_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .unit_crc    (unit_crc),
    .unit_data   (unit_data),
    .unit_result (unit_result)
  );

endmodule
